@@ rtl/sdes_pkg.sv @@
// S-DES counter mode cipher: shared types, tables and bit-level functions.
// Used by the datapath and the top level. It depends on no other file.
package sdes_pkg;

  typedef enum logic [1:0] {
    MODE_CTR = 2'd0,
    MODE_ENC = 2'd1,
    MODE_DEC = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_KEY  = 2'd0,
    REG_MODE = 2'd1,
    REG_INIT = 2'd2
  } reg_idx_t;

  // Mode and subkeys, handed from the top level to the datapath.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] k1;
    logic [7:0] k2;
  } sdes_ctl_t;

  // Bit positions are numbered from the MSB, starting at 0.
  localparam int unsigned TabIp    [8]  = '{1, 5, 2, 0, 3, 7, 4, 6};
  localparam int unsigned TabIpInv [8]  = '{3, 0, 2, 4, 6, 1, 7, 5};
  localparam int unsigned TabP4    [4]  = '{1, 3, 2, 0};
  localparam int unsigned TabEp    [8]  = '{3, 0, 1, 2, 1, 2, 3, 0};
  localparam int unsigned TabP10   [10] = '{2, 4, 1, 6, 3, 9, 0, 8, 7, 5};
  localparam int unsigned TabP8    [8]  = '{5, 2, 6, 3, 7, 4, 9, 8};

  // S-boxes flattened as {row, col}: row = {b3, b0}, col = {b2, b1}.
  localparam logic [1:0] BoxS0 [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [1:0] BoxS1 [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3};

  function automatic logic [7:0] perm_ip(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = x[7-TabIp[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ip_inv(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = x[7-TabIpInv[i]];
    return r;
  endfunction

  function automatic logic [3:0] perm_p4(input logic [3:0] x);
    logic [3:0] r;
    for (int i = 0; i < 4; i++) r[3-i] = x[3-TabP4[i]];
    return r;
  endfunction

  function automatic logic [7:0] expand_ep(input logic [3:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = x[3-TabEp[i]];
    return r;
  endfunction

  function automatic logic [9:0] perm_p10(input logic [9:0] x);
    logic [9:0] r;
    for (int i = 0; i < 10; i++) r[9-i] = x[9-TabP10[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_p8(input logic [9:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = x[9-TabP8[i]];
    return r;
  endfunction

  function automatic logic [4:0] rotl1(input logic [4:0] x);
    return {x[3:0], x[4]};
  endfunction

  function automatic logic [4:0] rotl2(input logic [4:0] x);
    return {x[2:0], x[4:3]};
  endfunction

  // Returns {K1, K2}.
  function automatic logic [15:0] key_schedule(input logic [9:0] key);
    logic [9:0] p;
    logic [4:0] hi1, lo1, hi2, lo2;
    p   = perm_p10(key);
    hi1 = rotl1(p[9:5]);
    lo1 = rotl1(p[4:0]);
    hi2 = rotl2(hi1);
    lo2 = rotl2(lo1);
    return {perm_p8({hi1, lo1}), perm_p8({hi2, lo2})};
  endfunction

  function automatic logic [3:0] round_f(input logic [3:0] r, input logic [7:0] sk);
    logic [7:0] e;
    logic [1:0] sa, sb;
    e  = expand_ep(r) ^ sk;
    sa = BoxS0[{e[7], e[4], e[6:5]}];
    sb = BoxS1[{e[3], e[0], e[2:1]}];
    return perm_p4({sa, sb});
  endfunction

endpackage

@@ rtl/sdes_if.sv @@
// Handshake channels of the S-DES cipher: data in, data out, register writes.
// Valid/ready with the payload; no dependencies.
interface sdes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       restart;
  modport source (output valid, data_in, restart, input ready);
  modport sink   (input valid, data_in, restart, output ready);
endinterface

interface sdes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

interface sdes_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sdes_counter_mode_cipher_top.sv @@
// Top level of the S-DES counter mode byte cipher: registers, counter, pipeline.
// Depends on sdes_pkg, the channel interfaces in sdes_if.sv and sdes_datapath.
//
//  channel | dir | beat payload           | notes
//  in_bus  | in  | data_in[7:0], restart  | one byte per beat
//  out_bus | out | data_out[7:0]          | one beat per input beat, in order
//  cfg_bus | in  | index[1:0], data[9:0]  | 0 key, 1 mode, 2 initial counter
//
// One byte per cycle sustained while out_bus takes its beats; a beat taken passes
// through the input register, then the result register behind the S-DES logic.
// Reset clears the registers and the counter to zero. A stall on out_bus
// fills the input register and then drops in_bus.ready; register writes are
// always taken and are only expected while the pipeline is empty.
module sdes_counter_mode_cipher_top (
  input  logic           clk,
  input  logic           rst_n,
  sdes_in_if.sink        in_bus,
  sdes_out_if.source     out_bus,
  sdes_cfg_if.sink       cfg_bus
);

  logic [9:0]        key_r;
  sdes_pkg::mode_t   mode_r;
  logic [7:0]        init_r;
  logic [7:0]        ctr_r, ctr_nxt;
  logic [7:0]        ctr_use;

  logic              s1_v_r;
  logic [7:0]        s1_blk_r, s1_data_r;
  logic              out_v_r;
  logic [7:0]        out_data_r;

  logic              in_acc, s1_adv, out_free;
  logic [15:0]       subkeys;
  sdes_pkg::sdes_ctl_t ctl;
  logic [7:0]        dp_out;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mode_r <= sdes_pkg::MODE_CTR;
      init_r <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        sdes_pkg::REG_KEY:  key_r  <= cfg_bus.data;
        sdes_pkg::REG_MODE: mode_r <= sdes_pkg::mode_t'(cfg_bus.data[1:0]);
        sdes_pkg::REG_INIT: init_r <= cfg_bus.data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_free      = !out_v_r || out_bus.ready;
  assign s1_adv        = s1_v_r && out_free;
  assign in_bus.ready  = !s1_v_r || out_free;
  assign in_acc        = in_bus.valid && in_bus.ready;

  // counter is taken as the byte enters, and advanced then only in counter mode
  always_comb begin
    ctr_use = in_bus.restart ? init_r : ctr_r;
    ctr_nxt = ctr_r;
    if (in_acc) begin
      ctr_nxt = (mode_r == sdes_pkg::MODE_CTR) ? ctr_use + 8'd1 : ctr_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      ctr_r <= ctr_nxt;
      if (in_bus.ready) s1_v_r <= in_bus.valid;
      if (out_free)     out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_blk_r  <= (mode_r == sdes_pkg::MODE_CTR) ? ctr_use : in_bus.data_in;
      s1_data_r <= in_bus.data_in;
    end
    if (s1_adv) out_data_r <= dp_out;
  end

  assign subkeys  = sdes_pkg::key_schedule(key_r);
  assign ctl.mode = mode_r;
  assign ctl.k1   = subkeys[15:8];
  assign ctl.k2   = subkeys[7:0];

  sdes_datapath u_dp (
    .ctl      (ctl),
    .blk_in   (s1_blk_r),
    .data_in  (s1_data_r),
    .data_out (dp_out)
  );

  assign out_bus.valid    = out_v_r;
  assign out_bus.data_out = out_data_r;

  // counter mode: each beat without restart steps the counter by one
  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_bus.restart && mode_r == sdes_pkg::MODE_CTR)
      |=> ctr_r == $past(ctr_r) + 8'd1)
    else $error("counter did not advance");

  // direct modes: counter holds unless restarted
  a_ctr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_bus.restart && mode_r != sdes_pkg::MODE_CTR) |=> ctr_r == $past(ctr_r))
    else $error("counter moved in a direct mode");

  // a result only appears behind a filled input register
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_v_r))
    else $error("result without an input beat");

  // input stalls only when both stages are full
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_v_r && out_v_r))
    else $error("input stalled with room in the pipeline");

endmodule

@@ rtl/sdes_datapath.sv @@
// S-DES block transform and mode selection for one byte (combinational).
// Uses sdes_pkg for tables, round function and control struct.
module sdes_datapath (
  input  sdes_pkg::sdes_ctl_t ctl,
  input  logic [7:0]          blk_in,   // counter in CTR mode, else the data byte
  input  logic [7:0]          data_in,
  output logic [7:0]          data_out
);

  logic [7:0] ka, kb;
  logic [7:0] ip_v, blk_out;
  logic [3:0] l1, r1, l2;

  always_comb begin
    // decryption runs the same rounds with the subkeys swapped
    if (ctl.mode == sdes_pkg::MODE_DEC) begin
      ka = ctl.k2;
      kb = ctl.k1;
    end else begin
      ka = ctl.k1;
      kb = ctl.k2;
    end
    ip_v    = sdes_pkg::perm_ip(blk_in);
    l1      = ip_v[7:4] ^ sdes_pkg::round_f(ip_v[3:0], ka);
    r1      = ip_v[3:0];
    // after SW: left = r1, right = l1
    l2      = r1 ^ sdes_pkg::round_f(l1, kb);
    blk_out = sdes_pkg::perm_ip_inv({l2, l1});
  end

  always_comb begin
    case (ctl.mode)
      sdes_pkg::MODE_CTR: data_out = data_in ^ blk_out;
      sdes_pkg::MODE_ENC,
      sdes_pkg::MODE_DEC: data_out = blk_out;
      default:            data_out = data_in;
    endcase
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the S-DES counter mode byte cipher top level.
// Needs sdes_pkg, the channel interfaces and the RTL; a scoreboard class
// predicts each output byte from the register writes and input beats it sees.
module tb_top;

  // Index 3 and mode 3 have no name in the package.
  localparam logic [1:0] RegUnused = 2'd3;
  localparam logic [1:0] ModeSpare = 2'd3;

  // Selection tables, entry i in nibble i counted from the top; bit 0 is the MSB.
  localparam logic [39:0] PermIp    = {4'd1, 4'd5, 4'd2, 4'd0, 4'd3, 4'd7, 4'd4, 4'd6, 8'd0};
  localparam logic [39:0] PermIpInv = {4'd3, 4'd0, 4'd2, 4'd4, 4'd6, 4'd1, 4'd7, 4'd5, 8'd0};
  localparam logic [39:0] PermP4    = {4'd1, 4'd3, 4'd2, 4'd0, 24'd0};
  localparam logic [39:0] PermEp    = {4'd3, 4'd0, 4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd0, 8'd0};
  localparam logic [39:0] PermP10   = {4'd2, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd0, 4'd8, 4'd7,
                                       4'd5};
  localparam logic [39:0] PermP8    = {4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8, 8'd0};

  // S-boxes, entry {row, col} with row = {b3, b0} and col = {b2, b1}.
  localparam logic [31:0] SBox0 = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                   2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [31:0] SBox1 = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                   2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  function automatic logic [9:0] permute(input logic [9:0] src, input logic [39:0] tab,
                                         input int n_in, input int n_out);
    logic [9:0] r;
    int pos;
    r = '0;
    for (int i = 0; i < n_out; i++) begin
      pos = n_in - 1 - int'(tab[39-4*i -: 4]);
      r[n_out-1-i] = src[pos];
    end
    return r;
  endfunction

  function automatic logic [1:0] sbox_lookup(input logic [31:0] box, input logic [3:0] nib);
    int k;
    k = int'({nib[3], nib[0], nib[2:1]});
    return box[31-2*k -: 2];
  endfunction

  function automatic logic [3:0] feistel_f(input logic [3:0] r, input logic [7:0] sk);
    logic [9:0] p;
    logic [7:0] e;
    logic [1:0] sa, sb;
    p  = permute({6'd0, r}, PermEp, 4, 8);
    e  = p[7:0] ^ sk;
    sa = sbox_lookup(SBox0, e[7:4]);
    sb = sbox_lookup(SBox1, e[3:0]);
    p  = permute({6'd0, sa, sb}, PermP4, 4, 4);
    return p[3:0];
  endfunction

  // {K1, K2}
  function automatic logic [15:0] derive_subkeys(input logic [9:0] key);
    logic [9:0] p, q;
    logic [4:0] hi, lo;
    logic [7:0] k1;
    p  = permute(key, PermP10, 10, 10);
    hi = {p[8:5], p[9]};
    lo = {p[3:0], p[4]};
    q  = permute({hi, lo}, PermP8, 10, 8);
    k1 = q[7:0];
    hi = {hi[2:0], hi[4:3]};
    lo = {lo[2:0], lo[4:3]};
    q  = permute({hi, lo}, PermP8, 10, 8);
    return {k1, q[7:0]};
  endfunction

  // IP, fK(ka), SW, fK(kb), IP^-1; decryption passes the subkeys swapped.
  function automatic logic [7:0] sdes_rounds(input logic [7:0] x, input logic [7:0] ka,
                                             input logic [7:0] kb);
    logic [9:0] p;
    logic [3:0] l, r, t;
    p = permute({2'b00, x}, PermIp, 8, 8);
    l = p[7:4];
    r = p[3:0];
    l = l ^ feistel_f(r, ka);
    t = l;
    l = r;
    r = t;
    l = l ^ feistel_f(r, kb);
    p = permute({2'b00, l, r}, PermIpInv, 8, 8);
    return p[7:0];
  endfunction

  class cipher_scoreboard;
    logic [9:0] key;
    logic [1:0] mode;
    logic [7:0] init_count;
    logic [7:0] counter;
    logic [7:0] expected_bytes[$];
    int         errors;

    function new();
      key        = '0;
      mode       = sdes_pkg::MODE_CTR;
      init_count = '0;
      counter    = '0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [9:0] value);
      case (idx)
        sdes_pkg::REG_KEY:  key = value;
        sdes_pkg::REG_MODE: mode = value[1:0];
        sdes_pkg::REG_INIT: init_count = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_input(input logic [7:0] data, input logic restart);
      logic [15:0] keys;
      logic [7:0]  res;
      if (restart) counter = init_count;
      keys = derive_subkeys(key);
      case (mode)
        sdes_pkg::MODE_CTR: begin
          res     = data ^ sdes_rounds(counter, keys[15:8], keys[7:0]);
          counter = counter + 8'd1;
        end
        sdes_pkg::MODE_ENC: res = sdes_rounds(data, keys[15:8], keys[7:0]);
        sdes_pkg::MODE_DEC: res = sdes_rounds(data, keys[7:0], keys[15:8]);
        default:  res = data;
      endcase
      expected_bytes.push_back(res);
    endfunction

    function void check_result(input logic [7:0] actual);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat: data_out=%02h", actual);
        return;
      end
      want = expected_bytes.pop_front();
      if (actual !== want) begin
        errors++;
        if (errors <= 10) $display("data_out mismatch: expected %02h, got %02h", want, actual);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sdes_in_if  in_bus ();
  sdes_out_if out_bus ();
  sdes_cfg_if cfg_bus ();

  sdes_counter_mode_cipher_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source),
    .cfg_bus (cfg_bus.sink)
  );

  cipher_scoreboard sb = new();

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_go       = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // results first, so a beat taken on the same edge cannot mask a stray one
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.data_out);
      if (in_bus.valid && in_bus.ready) sb.note_input(in_bus.data_in, in_bus.restart);
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  task automatic send_beat(input logic [7:0] d, input logic r);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.data_in <= d;
    in_bus.restart <= r;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
  endtask

  // Wait for every expected byte, then let the pipeline empty out.
  task automatic settle();
    do @(posedge clk); while (sb.expected_bytes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [9:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic shuffle_config();
    logic [9:0] key_val, junk;
    logic [7:0] init_val;
    logic [1:0] mode_val;
    int         pick;
    junk = 10'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 9);
      key_val = (pick == 0) ? 10'h000 : (pick == 1) ? 10'h3FF : 10'($urandom);
      put_reg(sdes_pkg::REG_KEY, key_val);
    end
    if ($urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      mode_val = sdes_pkg::MODE_CTR;
      else if (pick < 7) mode_val = sdes_pkg::MODE_ENC;
      else if (pick < 9) mode_val = sdes_pkg::MODE_DEC;
      else               mode_val = ModeSpare;
      put_reg(sdes_pkg::REG_MODE, {junk[9:2], mode_val});
    end
    if ($urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 9);
      init_val = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      put_reg(sdes_pkg::REG_INIT, {junk[1:0], init_val});
    end
    if ($urandom_range(0, 7) == 0) put_reg(RegUnused, 10'($urandom));
  endtask

  task automatic run_segment(input int n);
    logic [7:0] d;
    int         pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 15);
      d = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      send_beat(d, ($urandom_range(0, 9) == 0));
    end
    end_burst();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.data_in <= '0;
    in_bus.restart <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: counter mode, key zero, counter from zero
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h3C, 1'b1);
    end_burst();

    settle();
    put_reg(sdes_pkg::REG_KEY, 10'h3FF);
    put_reg(sdes_pkg::REG_MODE, {8'h00, sdes_pkg::MODE_ENC});
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hA5, 1'b0);
    end_burst();

    // decrypt; restart still reloads the counter though it is unused
    settle();
    put_reg(sdes_pkg::REG_MODE, {8'hFF, sdes_pkg::MODE_DEC});
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h5A, 1'b0);
    end_burst();

    // counter wraps from FF to 00
    settle();
    put_reg(sdes_pkg::REG_INIT, {2'b11, 8'hFE});
    put_reg(sdes_pkg::REG_MODE, {8'h00, sdes_pkg::MODE_CTR});
    send_beat(8'h11, 1'b1);
    send_beat(8'h22, 1'b0);
    send_beat(8'h33, 1'b0);
    send_beat(8'h44, 1'b0);
    end_burst();

    // new initial value only takes effect on restart
    settle();
    put_reg(sdes_pkg::REG_INIT, 10'h010);
    send_beat(8'h55, 1'b0);
    send_beat(8'h66, 1'b1);
    end_burst();

    // spare mode passes data through and holds the counter unless restarted
    settle();
    put_reg(sdes_pkg::REG_MODE, {8'h00, ModeSpare});
    send_beat(8'h77, 1'b0);
    send_beat(8'h88, 1'b1);
    end_burst();
    settle();
    put_reg(sdes_pkg::REG_MODE, {8'h00, sdes_pkg::MODE_CTR});
    send_beat(8'h99, 1'b0);
    end_burst();

    // write to an index past the register list is dropped
    settle();
    put_reg(RegUnused, 10'h2AA);
    send_beat(8'hAA, 1'b0);
    end_burst();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 52; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 52; end
        default: begin in_idle_pct = 36; out_stall_pct = 36; end
      endcase
      repeat (6) begin
        settle();
        shuffle_config();
        run_segment($urandom_range(20, 40));
      end
    end

    // long receiver hold-off against a sender that never pauses
    settle();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    shuffle_config();
    hold_go = 1'b1;
    run_segment(40);

    settle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sdes_pkg.sv
rtl/sdes_if.sv
rtl/sdes_datapath.sv
rtl/sdes_counter_mode_cipher_top.sv
tb/sv/tb_top.sv
